>>> design/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg
// Constants shared by the time command parser: character positions, the
// ASCII digit range and the field limits.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int unsigned POS_W  = 4;
    localparam int unsigned ACC2_W = 7;
    localparam int unsigned YEAR_W = 14;

    localparam logic [POS_W-1:0] POS_NONE  = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
    localparam logic [POS_W-1:0] POS_DAY   = 4'd2;
    localparam logic [POS_W-1:0] POS_MONTH = 4'd4;
    localparam logic [POS_W-1:0] POS_YEAR  = 4'd8;
    localparam logic [POS_W-1:0] POS_HOUR  = 4'd10;
    localparam logic [POS_W-1:0] POS_MIN   = 4'd12;
    localparam logic [POS_W-1:0] POS_LAST  = 4'd14;
    localparam logic [POS_W-1:0] POS_IDLE  = 4'd15;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    localparam logic [ACC2_W-1:0] DAY_MAX    = 7'd31;
    localparam logic [ACC2_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
    localparam logic [ACC2_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [ACC2_W-1:0] MINSEC_MAX = 7'd59;

endpackage

>>> design/time_command_parser.sv
// ----------------------------------------------------------------------------
// time_command_parser
// Parses a 14-character time command DDMMYYYYhhmmss (after a lead byte) and
// emits one result with a valid flag and the six fields.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_cmd_byte, i_starts_command
//  out     | output    | o_out_valid / i_out_ready | o_cmd_valid, o_day .. o_second
//
//  One byte per cycle; the result appears the cycle after the last digit
//  transfer, from a single output register.
//  Input is held off only while a result waits and the output is stalled.
//  Synchronous active-low reset leaves the parser idle, waiting for a start.
// ----------------------------------------------------------------------------
module time_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_cmd_byte,
    input  logic        i_starts_command,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_cmd_valid,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [13:0] o_year,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic [tcp_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [tcp_pkg::ACC2_W-1:0] r_day, n_day;
    logic [tcp_pkg::ACC2_W-1:0] r_month, n_month;
    logic [tcp_pkg::YEAR_W-1:0] r_year, n_year;
    logic [tcp_pkg::ACC2_W-1:0] r_hour, n_hour;
    logic [tcp_pkg::ACC2_W-1:0] r_minute, n_minute;
    logic [tcp_pkg::ACC2_W-1:0] r_second, n_second;
    logic                       r_bad, n_bad;

    logic        r_out_valid, n_out_valid;
    logic        r_ok;
    logic [4:0]  r_o_day;
    logic [3:0]  r_o_month;
    logic [13:0] r_o_year;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_minute;
    logic [5:0]  r_o_second;

    logic       xfer_in;
    logic       active;
    logic       is_digit;
    logic [3:0] digit;
    logic       finish;
    logic       ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign xfer_in    = i_in_valid && o_in_ready;
    assign active     = (r_pos != tcp_pkg::POS_NONE) && (r_pos <= tcp_pkg::POS_LAST);
    assign is_digit   = (i_cmd_byte >= tcp_pkg::ASCII_ZERO) &&
                        (i_cmd_byte <= tcp_pkg::ASCII_NINE);
    assign digit      = 4'(i_cmd_byte - tcp_pkg::ASCII_ZERO);
    assign finish     = xfer_in && !i_starts_command && (r_pos == tcp_pkg::POS_LAST);

    always_comb begin
        n_pos    = r_pos;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_bad    = r_bad;
        if (xfer_in) begin
            if (i_starts_command) begin
                n_pos    = tcp_pkg::POS_FIRST;
                n_day    = '0;
                n_month  = '0;
                n_year   = '0;
                n_hour   = '0;
                n_minute = '0;
                n_second = '0;
                n_bad    = 1'b0;
            end else if (active) begin
                n_pos = (r_pos == tcp_pkg::POS_LAST) ? tcp_pkg::POS_IDLE
                                                     : r_pos + 4'd1;
                if (!is_digit) begin
                    n_bad = 1'b1;
                end else if (r_pos <= tcp_pkg::POS_DAY) begin
                    n_day = (r_day << 3) + (r_day << 1) + {3'b0, digit};
                end else if (r_pos <= tcp_pkg::POS_MONTH) begin
                    n_month = (r_month << 3) + (r_month << 1) + {3'b0, digit};
                end else if (r_pos <= tcp_pkg::POS_YEAR) begin
                    n_year = (r_year << 3) + (r_year << 1) + {10'b0, digit};
                end else if (r_pos <= tcp_pkg::POS_HOUR) begin
                    n_hour = (r_hour << 3) + (r_hour << 1) + {3'b0, digit};
                end else if (r_pos <= tcp_pkg::POS_MIN) begin
                    n_minute = (r_minute << 3) + (r_minute << 1) + {3'b0, digit};
                end else begin
                    n_second = (r_second << 3) + (r_second << 1) + {3'b0, digit};
                end
            end
        end
    end

    assign ok = !n_bad &&
                (n_day != '0) && (n_day <= tcp_pkg::DAY_MAX) &&
                (n_month != '0) && (n_month <= tcp_pkg::MONTH_MAX) &&
                (n_year <= tcp_pkg::YEAR_MAX) &&
                (n_hour <= tcp_pkg::HOUR_MAX) &&
                (n_minute <= tcp_pkg::MINSEC_MAX) &&
                (n_second <= tcp_pkg::MINSEC_MAX);

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= tcp_pkg::POS_IDLE;
            r_day       <= '0;
            r_month     <= '0;
            r_year      <= '0;
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_second    <= n_second;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, zeroed when invalid
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_ok       <= ok;
            r_o_day    <= ok ? n_day[4:0]    : '0;
            r_o_month  <= ok ? n_month[3:0]  : '0;
            r_o_year   <= ok ? n_year        : '0;
            r_o_hour   <= ok ? n_hour[4:0]   : '0;
            r_o_minute <= ok ? n_minute[5:0] : '0;
            r_o_second <= ok ? n_second[5:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd_valid = r_ok;
    assign o_day       = r_o_day;
    assign o_month     = r_o_month;
    assign o_year      = r_o_year;
    assign o_hour      = r_o_hour;
    assign o_minute    = r_o_minute;
    assign o_second    = r_o_second;

`ifndef SYNTHESIS
    a_pos_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != tcp_pkg::POS_NONE)
        else $error("position counter reached zero");

    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cmd_valid |->
            o_day != 5'd0 && o_month != 4'd0 && o_month <= 4'd12 &&
            o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59)
        else $error("valid result with out-of-range field");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_cmd_valid |->
            o_day == 5'd0 && o_month == 4'd0 && o_year == 14'd0 &&
            o_hour == 5'd0 && o_minute == 6'd0 && o_second == 6'd0)
        else $error("invalid result with nonzero field");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(finish))
        else $error("result without final digit transfer");

    a_idle_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_pos == tcp_pkg::POS_IDLE)
        else $error("parser not idle after last digit");
`endif

endmodule

>>> dv/tb_time_command_parser.sv
// ----------------------------------------------------------------------------
// tb_time_command_parser
// Self-checking bench for the time command parser. Commands are queued as
// byte streams and sent over the input channel. A behavioral parser predicts
// each result on every input transfer. The monitor checks each output
// transfer field by field against the oldest prediction. Three phases vary
// the idle rates on both channels.
// ----------------------------------------------------------------------------
module tb_time_command_parser;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [7:0] ch;
        logic       lead;
    } t_cmd_char;

    typedef struct packed {
        logic        tc_valid;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } t_time_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_cmd_byte;
    logic        i_starts_command;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_cmd_valid;
    logic [4:0]  o_day;
    logic [3:0]  o_month;
    logic [13:0] o_year;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    t_cmd_char    pending_chars[$];
    t_time_result exp_times[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int queued_chars;
    int mismatches = 0;
    int stall_cycles = 0;

    // parser state as the block should hold it
    logic [tcp_pkg::POS_W-1:0] cur_pos = tcp_pkg::POS_IDLE;
    logic [6:0]        acc_day = '0;
    logic [6:0]        acc_month = '0;
    logic [13:0]       acc_year = '0;
    logic [6:0]        acc_hour = '0;
    logic [6:0]        acc_minute = '0;
    logic [6:0]        acc_sec = '0;
    logic              bad_seen = 1'b0;

    time_command_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd_byte       (i_cmd_byte),
        .i_starts_command (i_starts_command),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cmd_valid      (o_cmd_valid),
        .o_day            (o_day),
        .o_month          (o_month),
        .o_year           (o_year),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_second         (o_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic parse_char(input logic [7:0] ch, input logic lead);
        t_time_result r;
        logic [3:0]   d;
        logic         ok;
        if (lead) begin
            acc_day = '0;
            acc_month = '0;
            acc_year = '0;
            acc_hour = '0;
            acc_minute = '0;
            acc_sec = '0;
            bad_seen = 1'b0;
            cur_pos = tcp_pkg::POS_FIRST;
        end else if (cur_pos != tcp_pkg::POS_NONE && cur_pos <= tcp_pkg::POS_LAST) begin
            if (ch < tcp_pkg::ASCII_ZERO || ch > tcp_pkg::ASCII_NINE) begin
                bad_seen = 1'b1;
            end else begin
                d = 4'(ch - tcp_pkg::ASCII_ZERO);
                if (cur_pos <= tcp_pkg::POS_DAY)
                    acc_day = 7'(acc_day * 10 + d);
                else if (cur_pos <= tcp_pkg::POS_MONTH)
                    acc_month = 7'(acc_month * 10 + d);
                else if (cur_pos <= tcp_pkg::POS_YEAR)
                    acc_year = 14'(acc_year * 10 + d);
                else if (cur_pos <= tcp_pkg::POS_HOUR)
                    acc_hour = 7'(acc_hour * 10 + d);
                else if (cur_pos <= tcp_pkg::POS_MIN)
                    acc_minute = 7'(acc_minute * 10 + d);
                else
                    acc_sec = 7'(acc_sec * 10 + d);
            end
            if (cur_pos < tcp_pkg::POS_LAST) begin
                cur_pos = cur_pos + 1'b1;
            end else begin
                cur_pos = tcp_pkg::POS_IDLE;
                ok = !bad_seen &&
                     acc_day >= 1 && acc_day <= tcp_pkg::DAY_MAX &&
                     acc_month >= 1 && acc_month <= tcp_pkg::MONTH_MAX &&
                     acc_year <= tcp_pkg::YEAR_MAX &&
                     acc_hour <= tcp_pkg::HOUR_MAX &&
                     acc_minute <= tcp_pkg::MINSEC_MAX &&
                     acc_sec <= tcp_pkg::MINSEC_MAX;
                r = '0;
                if (ok) begin
                    r.tc_valid = 1'b1;
                    r.day      = acc_day[4:0];
                    r.month    = acc_month[3:0];
                    r.year     = acc_year;
                    r.hour     = acc_hour[4:0];
                    r.minute   = acc_minute[5:0];
                    r.sec      = acc_sec[5:0];
                end
                exp_times.push_back(r);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        t_cmd_char nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                parse_char(i_cmd_byte, i_starts_command);
            if (i_in_valid && !o_in_ready) begin
                // hold until transfer
            end else if (pending_chars.size() != 0 &&
                         $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = pending_chars.pop_front();
                i_in_valid       <= 1'b1;
                i_cmd_byte       <= nxt.ch;
                i_starts_command <= nxt.lead;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin : monitor
        t_time_result w;
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_times.size() == 0) begin
                $error("result transfer with no pending prediction");
                mismatches++;
            end else begin
                w = exp_times.pop_front();
                check_field("cmd_valid", int'(w.tc_valid), int'(o_cmd_valid));
                check_field("day", int'(w.day), int'(o_day));
                check_field("month", int'(w.month), int'(o_month));
                check_field("year", int'(w.year), int'(o_year));
                check_field("hour", int'(w.hour), int'(o_hour));
                check_field("minute", int'(w.minute), int'(o_minute));
                check_field("second", int'(w.sec), int'(o_second));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic queue_char(input logic [7:0] ch, input logic lead, input bit counts);
        t_cmd_char c;
        c.ch   = ch;
        c.lead = lead;
        pending_chars.push_back(c);
        if (counts)
            queued_chars++;
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0: ch = 8'(tcp_pkg::ASCII_ZERO - 1);
            1: ch = 8'(tcp_pkg::ASCII_NINE + 1);
            default: begin
                ch = tcp_pkg::ASCII_ZERO;
                while (ch >= tcp_pkg::ASCII_ZERO && ch <= tcp_pkg::ASCII_NINE)
                    ch = 8'($urandom_range(0, 255));
            end
        endcase
        return ch;
    endfunction

    // lead byte, then digits up to stop_at; a non-digit replaces position bad_at
    task automatic queue_time_cmd(input int dd, input int mm, input int yy, input int hh,
                                  input int mi, input int ss, input int bad_at,
                                  input int stop_at);
        string      txt;
        logic [7:0] ch;
        txt = $sformatf("%02d%02d%04d%02d%02d%02d", dd, mm, yy, hh, mi, ss);
        queue_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        for (int k = 1; k <= stop_at; k++) begin
            ch = (k == bad_at) ? non_digit() : txt[k-1];
            queue_char(ch, 1'b0, 1'b1);
        end
    endtask

    function automatic int pick_field(input int lo, input int hi, input int top,
                                      input bit wild);
        if (wild) begin
            case ($urandom_range(0, 3))
                0: return (lo > 0) ? lo - 1 : top;
                1: return (hi < top) ? hi + 1 : 0;
                2: return top;
                default: return $urandom_range(0, top);
            endcase
        end
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic queue_random_cmd();
        int kind;
        int wild_fld;
        int bad_at;
        int stop_at;
        int n_stray;
        kind     = $urandom_range(0, 99);
        wild_fld = (kind >= 55 && kind < 75) ? $urandom_range(0, 5) : -1;
        bad_at   = (kind >= 75 && kind < 85) ? $urandom_range(1, 14) : 0;
        stop_at  = (kind >= 85 && kind < 93) ? $urandom_range(0, 13) : 14;
        queue_time_cmd(pick_field(1, 31, 99, wild_fld == 0),
                       pick_field(1, 12, 99, wild_fld == 1),
                       pick_field(0, 9999, 9999, wild_fld == 2),
                       pick_field(0, 23, 99, wild_fld == 3),
                       pick_field(0, 59, 99, wild_fld == 4),
                       pick_field(0, 59, 99, wild_fld == 5),
                       bad_at, stop_at);
        if (kind >= 93) begin
            n_stray = $urandom_range(1, 3);
            repeat (n_stray)
                queue_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
    endtask

    task automatic fill_phase(input int target);
        queued_chars = 0;
        while (queued_chars < target)
            queue_random_cmd();
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_chars.size() != 0 || i_in_valid || exp_times.size() != 0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_cmd_byte       = '0;
        i_starts_command = 1'b0;
        i_out_ready      = 1'b0;
        tx_idle_pct      = 18;
        rx_idle_pct      = 80;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stray byte while idle, max and min commands, abandoned command,
        // non-digit at the last position
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_time_cmd(31, 12, 9999, 23, 59, 59, 0, 14);
        queue_char(tcp_pkg::ASCII_ZERO, 1'b0, 1'b0);
        queue_time_cmd(1, 1, 0, 0, 0, 0, 0, 3);
        queue_time_cmd(1, 1, 0, 0, 0, 0, 0, 14);
        queue_time_cmd(15, 6, 2024, 12, 30, 45, 14, 14);

        fill_phase(330);
        wait_drained();
        tx_idle_pct = 80;
        rx_idle_pct = 18;
        fill_phase(380);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_phase(390);
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
design/tcp_pkg.sv
design/time_command_parser.sv
dv/tb_time_command_parser.sv
